// ===== sv/apf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apf_pkg
// Shared codes and types of the articulation point finder.
// ----------------------------------------------------------------------------
package apf_pkg;

  localparam int unsigned NW = 9;  // node count and cut count width

  typedef enum logic [1:0] {
    ACT_ADD     = 2'd0,
    ACT_COMPUTE = 2'd1,
    ACT_QUERY   = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00_0000_0000_0001,
    S_ADD_A = 14'b00_0000_0000_0010,
    S_ADD_R = 14'b00_0000_0000_0100,
    S_ADD_B = 14'b00_0000_0000_1000,
    S_WIPE  = 14'b00_0000_0001_0000,
    S_ROOT  = 14'b00_0000_0010_0000,
    S_RCHK  = 14'b00_0000_0100_0000,
    S_VIS   = 14'b00_0000_1000_0000,
    S_STEP  = 14'b00_0001_0000_0000,
    S_SLOT  = 14'b00_0010_0000_0000,
    S_NBR   = 14'b00_0100_0000_0000,
    S_POP1  = 14'b00_1000_0000_0000,
    S_POP2  = 14'b01_0000_0000_0000,
    S_QRY   = 14'b10_0000_0000_0000
  } state_e;

endpackage
`default_nettype wire

// ===== sv/apf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apf_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module apf_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 256
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [$clog2(D)-1:0] waddr_i,
  input  wire logic [W-1:0]         wdata_i,
  input  wire logic [$clog2(D)-1:0] raddr_i,
  output logic      [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== sv/articulation_point_finder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// articulation_point_finder
// Cut vertices of an undirected graph by low-link depth-first search.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries action_i, end_a_i, end_b_i.
//   Every transfer yields exactly one result on the output channel
//   (out_valid_o/out_ready_i): status_o, is_cut_o and cut_count_o.
//   Clear and a failing query answer straight from idle, a good query
//   after one vertex store read; an add edge does two list head reads
//   and two slot writes on the single RAM ports.
//   A compute first clears all MAX_NODES vertex store entries, then checks
//   each candidate root, visits each vertex, reads and tests each slot
//   and returns along each tree edge.
//   node_count is written through cfg_we_i/cfg_wdata_i; the user must do so
//   only while idle, as the block itself does not enforce it.
//   One item is in work at a time; in_ready_o is high only when idle and
//   the output register is empty.
//   Reset sets node_count to 256, empties the edge store (list heads carry
//   valid flops), clears counts, and marks read as zero until the first
//   compute has cleared the vertex store.
//   If the receiver stalls, the result holds in the output register and no
//   new transfer is taken until it drains.
// ----------------------------------------------------------------------------
module articulation_point_finder #(
  parameter int unsigned MAX_NODES     = 256,
  parameter int unsigned MAX_ADJ_SLOTS = 2048
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [apf_pkg::NW-1:0] cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [1:0]             action_i,
  input  wire logic [7:0]             end_a_i,
  input  wire logic [7:0]             end_b_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [1:0]                  status_o,
  output logic                        is_cut_o,
  output logic [apf_pkg::NW-1:0]      cut_count_o
);

  localparam int unsigned NW = apf_pkg::NW;
  localparam int unsigned VW = $clog2(MAX_NODES);          // vertex index
  localparam int unsigned TW = $clog2(MAX_NODES + 1);      // times, depths
  localparam int unsigned AW = $clog2(MAX_ADJ_SLOTS);      // slot address
  localparam int unsigned PW = $clog2(MAX_ADJ_SLOTS + 1);  // slot pointer
  localparam logic [PW-1:0] NONE = PW'(MAX_ADJ_SLOTS);

  apf_pkg::state_e state_q, state_d;

  logic              out_valid_q, out_valid_d;
  apf_pkg::status_e  status_q, status_d;
  logic              is_cut_q, is_cut_d;
  logic [NW-1:0]     count_q, count_d;
  logic [NW-1:0]     node_count_q;
  logic [MAX_NODES-1:0] hval_q, hval_d;
  logic              wiped_q, wiped_d;
  logic [PW-1:0]     slots_q, slots_d;
  logic [TW-1:0]     total_q, total_d;
  logic [TW-1:0]     clock_q, clock_d;
  logic [TW-1:0]     rootc_q, rootc_d;
  logic [TW-1:0]     r_q, r_d;
  logic [TW-1:0]     sp_q, sp_d;
  logic [VW-1:0]     top_v_q, top_v_d;
  logic [PW-1:0]     top_c_q, top_c_d;
  logic [TW-1:0]     top_disc_q, top_disc_d;
  logic [TW-1:0]     top_low_q, top_low_d;
  logic              top_cut_q, top_cut_d;
  logic [VW-1:0]     par_v_q, par_v_d;
  logic [VW-1:0]     u_q, u_d;
  logic [VW-1:0]     ea_q, ea_d;
  logic [VW-1:0]     eb_q, eb_d;

  // RAM ports: list heads, adjacency slots, vertex marks and times, stack
  logic              h_we;
  logic [VW-1:0]     h_waddr, h_raddr;
  logic [PW-1:0]     h_wdata, h_rdata;
  logic              s_we;
  logic [AW-1:0]     s_waddr, s_raddr;
  logic [PW+VW-1:0]  s_wdata, s_rdata;
  logic              v_we;
  logic [VW-1:0]     v_waddr, v_raddr;
  logic [2*TW:0]     v_wdata, v_rdata;
  logic              k_we;
  logic [VW-1:0]     k_waddr, k_raddr;
  logic [VW+PW-1:0]  k_wdata, k_rdata;

  logic [NW-1:0]     live;
  logic              in_acc;
  logic              a_ok, b_ok, full;
  logic [PW-1:0]     slot_nx;
  logic [TW-1:0]     sp_m1, sp_m2;
  logic [VW-1:0]     u;
  logic [PW-1:0]     nxt;
  logic              p_cut;
  logic [TW-1:0]     p_disc, p_low;

  // A node count above the storage acts as the storage size
  assign live    = (32'(node_count_q) > MAX_NODES) ? NW'(MAX_NODES) : node_count_q;
  assign in_ready_o = (state_q == apf_pkg::S_IDLE) && !out_valid_q;
  assign in_acc  = in_valid_i && in_ready_o;
  assign a_ok    = 32'(end_a_i) < 32'(live);
  assign b_ok    = 32'(end_b_i) < 32'(live);
  assign full    = (32'(slots_q) + 32'd2) > MAX_ADJ_SLOTS;
  assign slot_nx = slots_q + PW'(1);
  assign sp_m1   = sp_q - TW'(1);
  assign sp_m2   = sp_q - TW'(2);
  assign u       = s_rdata[VW-1:0];
  assign nxt     = s_rdata[PW+VW-1:VW];
  // Vertex entry: cut mark, discovery time (zero while unvisited), low link
  assign p_cut   = v_rdata[2*TW];
  assign p_disc  = v_rdata[2*TW-1:TW];
  assign p_low   = v_rdata[TW-1:0];

  apf_ram #(.W(PW), .D(MAX_NODES)) u_head (
    .clk_i, .we_i(h_we), .waddr_i(h_waddr), .wdata_i(h_wdata),
    .raddr_i(h_raddr), .rdata_o(h_rdata)
  );

  apf_ram #(.W(PW + VW), .D(MAX_ADJ_SLOTS)) u_slot (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  apf_ram #(.W(2 * TW + 1), .D(MAX_NODES)) u_vtx (
    .clk_i, .we_i(v_we), .waddr_i(v_waddr), .wdata_i(v_wdata),
    .raddr_i(v_raddr), .rdata_o(v_rdata)
  );

  apf_ram #(.W(VW + PW), .D(MAX_NODES)) u_stack (
    .clk_i, .we_i(k_we), .waddr_i(k_waddr), .wdata_i(k_wdata),
    .raddr_i(k_raddr), .rdata_o(k_rdata)
  );

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    is_cut_d    = is_cut_q;
    count_d     = count_q;
    hval_d      = hval_q;
    wiped_d     = wiped_q;
    slots_d     = slots_q;
    total_d     = total_q;
    clock_d     = clock_q;
    rootc_d     = rootc_q;
    r_d         = r_q;
    sp_d        = sp_q;
    top_v_d     = top_v_q;
    top_c_d     = top_c_q;
    top_disc_d  = top_disc_q;
    top_low_d   = top_low_q;
    top_cut_d   = top_cut_q;
    par_v_d     = par_v_q;
    u_d         = u_q;
    ea_d        = ea_q;
    eb_d        = eb_q;
    h_we = 1'b0; h_waddr = '0; h_wdata = '0; h_raddr = '0;
    s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_raddr = '0;
    v_we = 1'b0; v_waddr = '0; v_wdata = '0; v_raddr = '0;
    k_we = 1'b0; k_waddr = '0; k_wdata = '0; k_raddr = '0;

    // Drop the result once the receiver takes it
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      apf_pkg::S_IDLE: begin
        if (in_acc) begin
          case (apf_pkg::action_e'(action_i))
            apf_pkg::ACT_ADD: begin
              if (!(a_ok && b_ok)) begin
                out_valid_d = 1'b1;
                status_d    = apf_pkg::ST_RANGE;
                is_cut_d    = 1'b0;
                count_d     = NW'(total_q);
              end else if (full) begin
                out_valid_d = 1'b1;
                status_d    = apf_pkg::ST_FULL;
                is_cut_d    = 1'b0;
                count_d     = NW'(total_q);
              end else begin
                ea_d    = VW'(end_a_i);
                eb_d    = VW'(end_b_i);
                h_raddr = VW'(end_a_i);
                state_d = apf_pkg::S_ADD_A;
              end
            end
            apf_pkg::ACT_COMPUTE: begin
              total_d = '0;
              clock_d = '0;
              r_d     = '0;
              state_d = apf_pkg::S_WIPE;
            end
            apf_pkg::ACT_QUERY: begin
              if (a_ok) begin
                v_raddr = VW'(end_a_i);
                state_d = apf_pkg::S_QRY;
              end else begin
                out_valid_d = 1'b1;
                count_d     = NW'(total_q);
                status_d    = apf_pkg::ST_RANGE;
                is_cut_d    = 1'b0;
              end
            end
            default: begin
              hval_d      = '0;
              slots_d     = '0;
              out_valid_d = 1'b1;
              status_d    = apf_pkg::ST_OK;
              is_cut_d    = 1'b0;
              count_d     = NW'(total_q);
            end
          endcase
        end
      end

      // Answer a query from the vertex store; marks read zero before a compute
      apf_pkg::S_QRY: begin
        out_valid_d = 1'b1;
        status_d    = apf_pkg::ST_OK;
        is_cut_d    = wiped_q ? p_cut : 1'b0;
        count_d     = NW'(total_q);
        state_d     = apf_pkg::S_IDLE;
      end

      // Link the slot pointing at end_b into end_a's list
      apf_pkg::S_ADD_A: begin
        s_we    = 1'b1;
        s_waddr = slots_q[AW-1:0];
        s_wdata = {(hval_q[ea_q] ? h_rdata : NONE), eb_q};
        h_we    = 1'b1;
        h_waddr = ea_q;
        h_wdata = slots_q;
        hval_d[ea_q] = 1'b1;
        state_d = apf_pkg::S_ADD_R;
      end

      // Read end_b's head after end_a's update has landed (self loops)
      apf_pkg::S_ADD_R: begin
        h_raddr = eb_q;
        state_d = apf_pkg::S_ADD_B;
      end

      apf_pkg::S_ADD_B: begin
        s_we    = 1'b1;
        s_waddr = slot_nx[AW-1:0];
        s_wdata = {(hval_q[eb_q] ? h_rdata : NONE), ea_q};
        h_we    = 1'b1;
        h_waddr = eb_q;
        h_wdata = slot_nx;
        hval_d[eb_q] = 1'b1;
        slots_d = slots_q + PW'(2);
        out_valid_d = 1'b1;
        status_d    = apf_pkg::ST_OK;
        is_cut_d    = 1'b0;
        count_d     = NW'(total_q);
        state_d     = apf_pkg::S_IDLE;
      end

      // Clear marks and times of every vertex, one entry a cycle
      apf_pkg::S_WIPE: begin
        v_we    = 1'b1;
        v_waddr = r_q[VW-1:0];
        v_wdata = '0;
        if (32'(r_q) == MAX_NODES - 1) begin
          r_d     = '0;
          wiped_d = 1'b1;
          state_d = apf_pkg::S_ROOT;
        end else begin
          r_d = r_q + TW'(1);
        end
      end

      // Pick the next root in ascending order and look up whether it is seen
      apf_pkg::S_ROOT: begin
        if (32'(r_q) >= 32'(live)) begin
          out_valid_d = 1'b1;
          status_d    = apf_pkg::ST_OK;
          is_cut_d    = 1'b0;
          count_d     = NW'(total_q);
          state_d     = apf_pkg::S_IDLE;
        end else begin
          v_raddr = r_q[VW-1:0];
          state_d = apf_pkg::S_RCHK;
        end
      end

      apf_pkg::S_RCHK: begin
        if (p_disc != '0) begin
          r_d     = r_q + TW'(1);
          state_d = apf_pkg::S_ROOT;
        end else begin
          rootc_d    = '0;
          sp_d       = TW'(1);
          clock_d    = clock_q + TW'(1);
          top_v_d    = r_q[VW-1:0];
          top_disc_d = clock_q + TW'(1);
          top_low_d  = clock_q + TW'(1);
          top_cut_d  = 1'b0;
          h_raddr    = r_q[VW-1:0];
          state_d    = apf_pkg::S_VIS;
        end
      end

      // Record discovery time of the new top, load its list head
      apf_pkg::S_VIS: begin
        v_we    = 1'b1;
        v_waddr = top_v_q;
        v_wdata = {1'b0, top_disc_q, top_low_q};
        top_c_d = hval_q[top_v_q] ? h_rdata : NONE;
        state_d = apf_pkg::S_STEP;
      end

      apf_pkg::S_STEP: begin
        if (top_c_q != NONE) begin
          s_raddr = top_c_q[AW-1:0];
          state_d = apf_pkg::S_SLOT;
        end else if (sp_q > TW'(1)) begin
          sp_d    = sp_m1;
          v_raddr = par_v_q;
          k_raddr = sp_m2[VW-1:0];
          state_d = apf_pkg::S_POP1;
        end else begin
          // Root done: a cut vertex if it has more than one tree child
          if (rootc_q > TW'(1) && !top_cut_q) begin
            v_we    = 1'b1;
            v_waddr = top_v_q;
            v_wdata = {1'b1, top_disc_q, top_low_q};
            total_d = total_q + TW'(1);
          end
          r_d     = r_q + TW'(1);
          state_d = apf_pkg::S_ROOT;
        end
      end

      // Skip neighbours out of range and the tree parent, look up the rest
      apf_pkg::S_SLOT: begin
        top_c_d = nxt;
        if (32'(u) >= 32'(live)) begin
          state_d = apf_pkg::S_STEP;
        end else if (sp_q > TW'(1) && u == par_v_q) begin
          state_d = apf_pkg::S_STEP;
        end else begin
          v_raddr = u;
          u_d     = u;
          state_d = apf_pkg::S_NBR;
        end
      end

      apf_pkg::S_NBR: begin
        if (p_disc != '0) begin
          if (p_disc < top_low_q) begin
            top_low_d = p_disc;
          end
          state_d = apf_pkg::S_STEP;
        end else if (32'(sp_q) < MAX_NODES) begin
          // Descend: spill the current frame, its mark and its low link
          k_we       = 1'b1;
          k_waddr    = sp_m1[VW-1:0];
          k_wdata    = {top_v_q, top_c_q};
          v_we       = 1'b1;
          v_waddr    = top_v_q;
          v_wdata    = {top_cut_q, top_disc_q, top_low_q};
          par_v_d    = top_v_q;
          clock_d    = clock_q + TW'(1);
          top_v_d    = u_q;
          top_disc_d = clock_q + TW'(1);
          top_low_d  = clock_q + TW'(1);
          top_cut_d  = 1'b0;
          sp_d       = sp_q + TW'(1);
          h_raddr    = u_q;
          state_d    = apf_pkg::S_VIS;
        end else begin
          state_d = apf_pkg::S_STEP;
        end
      end

      // Return to the parent: fold the child's low link into it
      apf_pkg::S_POP1: begin
        top_low_d  = (top_low_q < p_low) ? top_low_q : p_low;
        top_v_d    = par_v_q;
        top_disc_d = p_disc;
        top_cut_d  = p_cut;
        top_c_d    = k_rdata[PW-1:0];
        if (sp_q == TW'(1)) begin
          rootc_d = rootc_q + TW'(1);
        end else if (top_low_q >= p_disc && !p_cut) begin
          v_we      = 1'b1;
          v_waddr   = par_v_q;
          v_wdata   = {1'b1, p_disc, p_low};
          top_cut_d = 1'b1;
          total_d   = total_q + TW'(1);
        end
        if (sp_q >= TW'(2)) begin
          k_raddr = sp_m2[VW-1:0];
          state_d = apf_pkg::S_POP2;
        end else begin
          state_d = apf_pkg::S_STEP;
        end
      end

      apf_pkg::S_POP2: begin
        par_v_d = k_rdata[VW+PW-1:PW];
        state_d = apf_pkg::S_STEP;
      end

      default: begin
        state_d = apf_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= apf_pkg::S_IDLE;
      out_valid_q  <= 1'b0;
      node_count_q <= NW'(256);
      hval_q       <= '0;
      wiped_q      <= 1'b0;
      slots_q      <= '0;
      total_q      <= '0;
      clock_q      <= '0;
      rootc_q      <= '0;
      r_q          <= '0;
      sp_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      hval_q  <= hval_d;
      wiped_q <= wiped_d;
      slots_q <= slots_d;
      total_q <= total_d;
      clock_q <= clock_d;
      rootc_q <= rootc_d;
      r_q     <= r_d;
      sp_q    <= sp_d;
    end
  end

  // Payload registers hold without reset
  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    is_cut_q   <= is_cut_d;
    count_q    <= count_d;
    top_v_q    <= top_v_d;
    top_c_q    <= top_c_d;
    top_disc_q <= top_disc_d;
    top_low_q  <= top_low_d;
    top_cut_q  <= top_cut_d;
    par_v_q    <= par_v_d;
    u_q        <= u_d;
    ea_q       <= ea_d;
    eb_q       <= eb_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign is_cut_o    = is_cut_q;
  assign cut_count_o = count_q;

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(sp_q) <= MAX_NODES)
    else $error("search stack depth beyond storage");

  a_slots_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(slots_q) <= MAX_ADJ_SLOTS)
    else $error("slot fill beyond storage");

  a_root_wiped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == apf_pkg::S_ROOT |-> wiped_q)
    else $error("search started on an uncleared vertex store");

  a_query_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && action_i == apf_pkg::ACT_QUERY |=>
      out_valid_o || state_q == apf_pkg::S_QRY)
    else $error("query neither answered nor looked up in the next cycle");

  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != apf_pkg::S_IDLE |-> !in_ready_o)
    else $error("transfer taken while busy");

endmodule
`default_nettype wire
